>>> hw/rtl/triangle_angles_from_sides_defines.svh
// assertion macros shared by the triangle angle checker
// no dependencies
`ifndef TRIANGLE_ANGLES_FROM_SIDES_DEFINES_SVH
`define TRIANGLE_ANGLES_FROM_SIDES_DEFINES_SVH

// condition implies consequence in the same cycle
`define TAFS_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TAFS_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/tafs_pkg.sv
// shared widths, constants, control struct and arc tangent table
// for the triangle angle pipeline; no dependencies
package tafs_pkg;

  localparam int SIDE_W          = 16;
  localparam int ANGLE_W         = 16;
  localparam int IN_W            = 3 * SIDE_W;
  localparam int OUT_W           = 3 * ANGLE_W;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ACOS_ITER_DEF   = 16;
  localparam int ATAN_LEN        = 24;

  localparam int SQ_W     = 2 * SIDE_W;
  localparam int NUM_W    = SQ_W + 2;
  localparam int DEN_W    = SQ_W + 1;
  localparam int REM_W    = SQ_W + 2;
  localparam int QUO_BITS = 17;
  localparam int COS_W    = QUO_BITS + 1;
  localparam int SIN_W    = QUO_BITS;
  localparam int RAD_W    = 2 * QUO_BITS - 1;
  localparam int ROOT_W   = 2 * QUO_BITS;
  localparam int XY_W     = 34;
  localparam int XY_SHIFT = 14;
  localparam int Z_W      = 26;
  localparam int ZQ_W     = 24;
  localparam int ATAN_W   = 22;

  localparam logic [QUO_BITS-1:0] ONE_Q16    = QUO_BITS'(65536);
  localparam logic [ZQ_W-1:0]     DEG90_Q16  = ZQ_W'(90 * 65536);
  localparam logic [ZQ_W-1:0]     DEG180_Q16 = ZQ_W'(180 * 65536);
  localparam int                  FULL_DEG   = 180 << ANGLE_FRAC_BITS;

  typedef struct packed {
    logic valid;
    logic tri_ok;
  } tafs_ctl_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [ATAN_W-1:0] atan_deg_q16(input int unsigned idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:  v = ATAN_W'(2949120);
      1:  v = ATAN_W'(1740967);
      2:  v = ATAN_W'(919879);
      3:  v = ATAN_W'(466945);
      4:  v = ATAN_W'(234379);
      5:  v = ATAN_W'(117304);
      6:  v = ATAN_W'(58666);
      7:  v = ATAN_W'(29335);
      8:  v = ATAN_W'(14668);
      9:  v = ATAN_W'(7334);
      10: v = ATAN_W'(3667);
      11: v = ATAN_W'(1833);
      12: v = ATAN_W'(917);
      13: v = ATAN_W'(458);
      14: v = ATAN_W'(229);
      15: v = ATAN_W'(115);
      16: v = ATAN_W'(57);
      17: v = ATAN_W'(29);
      18: v = ATAN_W'(14);
      19: v = ATAN_W'(7);
      20: v = ATAN_W'(4);
      21: v = ATAN_W'(2);
      22: v = ATAN_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tafs_cosine.sv
// cosine lane: squares, law of cosines terms and a pipelined restoring divider
// giving a signed Q1.16 cosine; depends on tafs_pkg
module tafs_cosine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  tafs_pkg::tafs_ctl_t                 in_ctl,
  input  logic [tafs_pkg::SIDE_W-1:0]         side_p,
  input  logic [tafs_pkg::SIDE_W-1:0]         side_q,
  input  logic [tafs_pkg::SIDE_W-1:0]         side_r,
  output tafs_pkg::tafs_ctl_t                 out_ctl,
  output logic signed [tafs_pkg::COS_W-1:0]   cos_q16
);
  import tafs_pkg::*;

  localparam int STEPS = QUO_BITS;

  tafs_ctl_t               ctl1, ctl2;
  logic [SQ_W-1:0]         sq_p, sq_q, sq_r, prod_qr;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]        den2;
  logic [NUM_W-1:0]        num_mag;

  tafs_ctl_t               d_ctl  [0:STEPS];
  logic [REM_W-1:0]        d_rem  [0:STEPS];
  logic [QUO_BITS-1:0]     d_quo  [0:STEPS];
  logic [DEN_W-1:0]        d_den  [0:STEPS];
  logic                    d_neg  [0:STEPS];
  logic                    d_zero [0:STEPS];
  logic                    d_sat  [0:STEPS];
  logic [REM_W-1:0]        rem_sh [1:STEPS];
  logic                    ge     [1:STEPS];

  logic [QUO_BITS:0]       q_round;
  logic [QUO_BITS-1:0]     mag_val;

  // magnitude of the numerator
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // one quotient bit per stage
  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      rem_sh[k] = {d_rem[k-1][REM_W-2:0], 1'b0};
      ge[k]     = (rem_sh[k] >= {1'b0, d_den[k-1]});
    end
  end

  // control travels with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
      for (int k = 0; k <= STEPS; k++) d_ctl[k] <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl1     <= in_ctl;
      ctl2     <= ctl1;
      d_ctl[0] <= ctl2;
      for (int k = 1; k <= STEPS; k++) d_ctl[k] <= d_ctl[k-1];
      out_ctl  <= d_ctl[STEPS];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      sq_p    <= side_p * side_p;
      sq_q    <= side_q * side_q;
      sq_r    <= side_r * side_r;
      prod_qr <= side_q * side_r;
      num     <= $signed({2'b00, sq_q}) + $signed({2'b00, sq_r}) - $signed({2'b00, sq_p});
      den2    <= {prod_qr, 1'b0};
      d_rem[0]  <= REM_W'(num_mag);
      d_quo[0]  <= '0;
      d_den[0]  <= den2;
      d_neg[0]  <= num[NUM_W-1];
      d_zero[0] <= (num_mag == '0);
      d_sat[0]  <= (den2 == '0) || (num_mag >= NUM_W'(den2));
      for (int k = 1; k <= STEPS; k++) begin
        d_rem[k]  <= ge[k] ? rem_sh[k] - {1'b0, d_den[k-1]} : rem_sh[k];
        d_quo[k]  <= {d_quo[k-1][QUO_BITS-2:0], ge[k]};
        d_den[k]  <= d_den[k-1];
        d_neg[k]  <= d_neg[k-1];
        d_zero[k] <= d_zero[k-1];
        d_sat[k]  <= d_sat[k-1];
      end
      cos_q16 <= d_neg[STEPS] ? -$signed({1'b0, mag_val}) : $signed({1'b0, mag_val});
    end
  end

  // round the 17-bit quotient to Q16 and apply special cases
  assign q_round = {1'b0, d_quo[STEPS]} + (QUO_BITS+1)'(1);
  always_comb begin
    if (d_zero[STEPS])     mag_val = '0;
    else if (d_sat[STEPS]) mag_val = ONE_Q16;
    else                   mag_val = q_round[QUO_BITS:1];
  end

endmodule

>>> hw/rtl/tafs_sine.sv
// sine lane: sin = sqrt(1 - cos^2) with a pipelined integer square root,
// one result bit per stage; depends on tafs_pkg
module tafs_sine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  tafs_pkg::tafs_ctl_t                in_ctl,
  input  logic signed [tafs_pkg::COS_W-1:0]  cos_in,
  output tafs_pkg::tafs_ctl_t                out_ctl,
  output logic signed [tafs_pkg::COS_W-1:0]  cos_out,
  output logic [tafs_pkg::SIN_W-1:0]         sin_q16
);
  import tafs_pkg::*;

  localparam int STEPS = SIN_W;
  localparam logic [RAD_W-1:0] ONE_SQ = RAD_W'(1) << (2 * (SIN_W - 1));

  tafs_ctl_t                ctl_m;
  logic signed [COS_W-1:0]  cos_m;
  logic [RAD_W-1:0]         msq;
  logic [SIN_W-1:0]         cmag;

  tafs_ctl_t                r_ctl [0:STEPS];
  logic signed [COS_W-1:0]  r_cos [0:STEPS];
  logic [RAD_W-1:0]         r_v   [0:STEPS];
  logic [ROOT_W-1:0]        r_res [0:STEPS];
  logic [ROOT_W-1:0]        bitv  [1:STEPS];
  logic [ROOT_W-1:0]        trial [1:STEPS];
  logic                     fits  [1:STEPS];

  assign cmag = cos_in[COS_W-1] ? SIN_W'(-cos_in) : SIN_W'(cos_in);

  // trial subtraction for each root bit
  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      bitv[k]  = ROOT_W'(1) << (2 * (SIN_W - k));
      trial[k] = r_res[k-1] + bitv[k];
      fits[k]  = ({1'b0, r_v[k-1]} >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m <= '0;
      for (int k = 0; k <= STEPS; k++) r_ctl[k] <= '0;
    end else if (en) begin
      ctl_m    <= in_ctl;
      r_ctl[0] <= ctl_m;
      for (int k = 1; k <= STEPS; k++) r_ctl[k] <= r_ctl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_m    <= cos_in;
      msq      <= RAD_W'(cmag) * RAD_W'(cmag);
      r_cos[0] <= cos_m;
      r_v[0]   <= ONE_SQ - msq;
      r_res[0] <= '0;
      for (int k = 1; k <= STEPS; k++) begin
        r_cos[k] <= r_cos[k-1];
        if (fits[k]) begin
          r_v[k]   <= RAD_W'({1'b0, r_v[k-1]} - trial[k]);
          r_res[k] <= (r_res[k-1] >> 1) + bitv[k];
        end else begin
          r_v[k]   <= r_v[k-1];
          r_res[k] <= r_res[k-1] >> 1;
        end
      end
    end
  end

  assign out_ctl = r_ctl[STEPS];
  assign cos_out = r_cos[STEPS];
  assign sin_q16 = r_res[STEPS][SIN_W-1:0];

endmodule

>>> hw/rtl/tafs_cordic.sv
// vectoring cordic: angle of (cos, sin) in degrees Q16, one rotation per
// stage, clamped to [0, 180]; depends on tafs_pkg
module tafs_cordic #(
  parameter int ITERS = tafs_pkg::ACOS_ITER_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  tafs_pkg::tafs_ctl_t                in_ctl,
  input  logic signed [tafs_pkg::COS_W-1:0]  cos_in,
  input  logic [tafs_pkg::SIN_W-1:0]         sin_in,
  output tafs_pkg::tafs_ctl_t                out_ctl,
  output logic [tafs_pkg::ZQ_W-1:0]          angle_q16
);
  import tafs_pkg::*;

  tafs_ctl_t               c_ctl [0:ITERS];
  logic signed [XY_W-1:0]  c_x   [0:ITERS];
  logic signed [XY_W-1:0]  c_y   [0:ITERS];
  logic signed [Z_W-1:0]   c_z   [0:ITERS];
  logic signed [XY_W-1:0]  xs    [1:ITERS];
  logic signed [XY_W-1:0]  ys    [1:ITERS];
  logic signed [Z_W-1:0]   step  [1:ITERS];
  logic signed [XY_W-1:0]  x_in, y_in;

  assign x_in = XY_W'(cos_in) <<< XY_SHIFT;
  assign y_in = $signed(XY_W'(sin_in)) <<< XY_SHIFT;

  always_comb begin
    for (int k = 1; k <= ITERS; k++) begin
      xs[k]   = c_x[k-1] >>> (k - 1);
      ys[k]   = c_y[k-1] >>> (k - 1);
      step[k] = $signed(Z_W'(atan_deg_q16(k - 1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ITERS; k++) c_ctl[k] <= '0;
      out_ctl <= '0;
    end else if (en) begin
      c_ctl[0] <= in_ctl;
      for (int k = 1; k <= ITERS; k++) c_ctl[k] <= c_ctl[k-1];
      out_ctl <= c_ctl[ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // left half plane: pre-rotate by 90 degrees
      if (x_in < 0) begin
        c_x[0] <= y_in;
        c_y[0] <= -x_in;
        c_z[0] <= $signed(Z_W'(DEG90_Q16));
      end else begin
        c_x[0] <= x_in;
        c_y[0] <= y_in;
        c_z[0] <= '0;
      end
      for (int k = 1; k <= ITERS; k++) begin
        if (c_y[k-1] > 0) begin
          c_x[k] <= c_x[k-1] + ys[k];
          c_y[k] <= c_y[k-1] - xs[k];
          c_z[k] <= c_z[k-1] + step[k];
        end else begin
          c_x[k] <= c_x[k-1] - ys[k];
          c_y[k] <= c_y[k-1] + xs[k];
          c_z[k] <= c_z[k-1] - step[k];
        end
      end
      // clamp to [0, 180] degrees
      if (c_z[ITERS] < 0)
        angle_q16 <= '0;
      else if (c_z[ITERS] > $signed(Z_W'(DEG180_Q16)))
        angle_q16 <= DEG180_Q16;
      else
        angle_q16 <= ZQ_W'(c_z[ITERS]);
    end
  end

endmodule

>>> hw/rtl/triangle_angles_from_sides.sv
// triangle angles from three sides: one item per cycle sustained; the whole
// pipeline advances when the output register is empty or taken, so a stall
// holds every stage in place
// longest stages: one quotient bit, one root bit or one cordic rotation each
// rst (synchronous, active high) clears all valid bits; no data is cleared
// depends on tafs_pkg, tafs_cosine, tafs_sine, tafs_cordic
module triangle_angles_from_sides #(
  parameter int ACOS_ITERATIONS = tafs_pkg::ACOS_ITER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tafs_pkg::IN_W-1:0]   s_tdata,   // side_a, side_b, side_c
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tafs_pkg::OUT_W-1:0]  m_tdata,   // angle_a, angle_b, angle_c
  output logic [0:0]                  m_tuser    // is_triangle
);
  import tafs_pkg::*;

  localparam int RND_SHIFT = 16 - ANGLE_FRAC_BITS;
  localparam int HALF      = (ANGLE_FRAC_BITS < 16) ? (1 << (15 - ANGLE_FRAC_BITS)) : 0;
  localparam int RND_W     = ZQ_W + 1;
  localparam int DIFF_W    = RND_W + 2;

  logic                        en;
  tafs_ctl_t                   ctl_in;
  logic [SIDE_W-1:0]           side_a, side_b, side_c;
  logic                        tri_ok;

  tafs_ctl_t                   ca_ctl, cb_ctl, sa_ctl, sb_ctl, za_ctl, zb_ctl;
  logic signed [COS_W-1:0]     ca_cos, cb_cos, sa_cos, sb_cos;
  logic [SIN_W-1:0]            sa_sin, sb_sin;
  logic [ZQ_W-1:0]             za_ang, zb_ang;

  logic [RND_W-1:0]            rnd_a, rnd_b;
  logic signed [DIFF_W-1:0]    diff_c;
  logic [ANGLE_W-1:0]          out_a, out_b, out_c;

  // the pipeline moves when the output register can take an item
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // strict triangle inequality on all three pairs
  assign tri_ok = ({1'b0, s_tdata[SIDE_W-1:0]} + {1'b0, s_tdata[2*SIDE_W-1:SIDE_W]}
                     > {1'b0, s_tdata[3*SIDE_W-1:2*SIDE_W]})
               && ({1'b0, s_tdata[2*SIDE_W-1:SIDE_W]} + {1'b0, s_tdata[3*SIDE_W-1:2*SIDE_W]}
                     > {1'b0, s_tdata[SIDE_W-1:0]})
               && ({1'b0, s_tdata[SIDE_W-1:0]} + {1'b0, s_tdata[3*SIDE_W-1:2*SIDE_W]}
                     > {1'b0, s_tdata[2*SIDE_W-1:SIDE_W]});

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_in <= '0;
    end else if (en) begin
      ctl_in.valid  <= s_tvalid;
      ctl_in.tri_ok <= tri_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= s_tdata[SIDE_W-1:0];
      side_b <= s_tdata[2*SIDE_W-1:SIDE_W];
      side_c <= s_tdata[3*SIDE_W-1:2*SIDE_W];
    end
  end

  // lane for angle a
  tafs_cosine u_cos_a (
    .clk, .rst, .en, .in_ctl(ctl_in),
    .side_p(side_a), .side_q(side_b), .side_r(side_c),
    .out_ctl(ca_ctl), .cos_q16(ca_cos)
  );
  tafs_sine u_sin_a (
    .clk, .rst, .en, .in_ctl(ca_ctl), .cos_in(ca_cos),
    .out_ctl(sa_ctl), .cos_out(sa_cos), .sin_q16(sa_sin)
  );
  tafs_cordic #(.ITERS(ACOS_ITERATIONS)) u_cordic_a (
    .clk, .rst, .en, .in_ctl(sa_ctl), .cos_in(sa_cos), .sin_in(sa_sin),
    .out_ctl(za_ctl), .angle_q16(za_ang)
  );

  // lane for angle b
  tafs_cosine u_cos_b (
    .clk, .rst, .en, .in_ctl(ctl_in),
    .side_p(side_b), .side_q(side_a), .side_r(side_c),
    .out_ctl(cb_ctl), .cos_q16(cb_cos)
  );
  tafs_sine u_sin_b (
    .clk, .rst, .en, .in_ctl(cb_ctl), .cos_in(cb_cos),
    .out_ctl(sb_ctl), .cos_out(sb_cos), .sin_q16(sb_sin)
  );
  tafs_cordic #(.ITERS(ACOS_ITERATIONS)) u_cordic_b (
    .clk, .rst, .en, .in_ctl(sb_ctl), .cos_in(sb_cos), .sin_in(sb_sin),
    .out_ctl(zb_ctl), .angle_q16(zb_ang)
  );

  // round to the output format, third angle by difference, saturate
  assign rnd_a  = ({1'b0, za_ang} + RND_W'(HALF)) >> RND_SHIFT;
  assign rnd_b  = ({1'b0, zb_ang} + RND_W'(HALF)) >> RND_SHIFT;
  assign diff_c = DIFF_W'(FULL_DEG) - $signed({2'b00, rnd_a}) - $signed({2'b00, rnd_b});

  assign out_a = (rnd_a > RND_W'({ANGLE_W{1'b1}})) ? {ANGLE_W{1'b1}} : rnd_a[ANGLE_W-1:0];
  assign out_b = (rnd_b > RND_W'({ANGLE_W{1'b1}})) ? {ANGLE_W{1'b1}} : rnd_b[ANGLE_W-1:0];
  always_comb begin
    if (diff_c < 0)
      out_c = '0;
    else if (diff_c > $signed(DIFF_W'({ANGLE_W{1'b1}})))
      out_c = {ANGLE_W{1'b1}};
    else
      out_c = diff_c[ANGLE_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= za_ctl.valid & zb_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (za_ctl.tri_ok & zb_ctl.tri_ok) begin
        m_tuser <= 1'b1;
        m_tdata <= {out_c, out_b, out_a};
      end else begin
        m_tuser <= 1'b0;
        m_tdata <= '0;
      end
    end
  end

endmodule

>>> hw/rtl/tafs_checker.sv
// port-level checks for the triangle angle block, bound to the top level
// depends on tafs_pkg and triangle_angles_from_sides_defines.svh
`include "triangle_angles_from_sides_defines.svh"

module tafs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [tafs_pkg::OUT_W-1:0]  m_tdata,
  input logic [0:0]                  m_tuser
);
  import tafs_pkg::*;

  logic [OUT_W:0] out_item;
  logic           angles_ok;

  assign out_item  = {m_tuser, m_tdata};
  assign angles_ok = (m_tdata[15:0] <= 16'(FULL_DEG)) && (m_tdata[31:16] <= 16'(FULL_DEG))
                  && (m_tdata[47:32] <= 16'(FULL_DEG));

  // a held result keeps its value
  `TAFS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_item), "result changed")

  // non-triangles report all angles zero
  `TAFS_ASSERT_NOW(a_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "angles nonzero")

  // every angle stays within 180 degrees
  `TAFS_ASSERT_NOW(a_range, m_tvalid && m_tuser[0], angles_ok, "angle above 180 degrees")

  // input side is ready whenever the output register has room
  `TAFS_ASSERT_NOW(a_ready, !m_tvalid || m_tready, s_tready, "input stalled with room")

endmodule

bind triangle_angles_from_sides tafs_checker u_tafs_checker (.*);

>>> verif/triangle_angles_from_sides_tb.sv
// testbench for triangle_angles_from_sides: drives side triples on the input
// stream and compares every output item with a law-of-cosines angle predictor
// depends on tafs_pkg and the triangle_angles_from_sides rtl
`timescale 1ns / 100ps

module triangle_angles_from_sides_tb;
  import tafs_pkg::*;

  localparam int LATENCY = 44 + ACOS_ITER_DEF;

  typedef struct packed {
    logic              tri_ok;
    logic [ANGLE_W-1:0] ang_a;
    logic [ANGLE_W-1:0] ang_b;
    logic [ANGLE_W-1:0] ang_c;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  angles_t pending_angles[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  triangle_angles_from_sides dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // floor division by 2^s for signed values
  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // rounded signed q1.16 quotient
  function automatic longint cosine_q16(longint num, longint den);
    longint mag;
    longint q;
    longint r;
    mag = (num < 0) ? -num : num;
    if (mag == 0) return 0;
    if (den == 0 || mag >= den) begin
      q = 65536;
    end else begin
      r = mag;
      q = 0;
      for (int k = 0; k < QUO_BITS; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      q = (q + 1) >> 1;
    end
    return (num < 0) ? -q : q;
  endfunction

  // atan(2^-i) in degrees q16
  function automatic int atan_step_deg(int i);
    int steps[ATAN_LEN] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return steps[i];
  endfunction

  // arc cosine by cordic vectoring, degrees q16, then output format
  function automatic longint acos_out(longint cq);
    longint sq;
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    sq = (cq < 0) ? -cq : cq;
    x = cq * 16384;
    y = int_sqrt((64'd1 << 32) - sq * sq) * 16384;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 90 * 65536;
    end
    for (int i = 0; i < ACOS_ITER_DEF && i < ATAN_LEN; i++) begin
      xs = fl_shift(x, i);
      ys = fl_shift(y, i);
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(atan_step_deg(i));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(atan_step_deg(i));
      end
    end
    if (z < 0) z = 0;
    if (z > 180 * 65536) z = 180 * 65536;
    return (z + (longint'(1) << (15 - ANGLE_FRAC_BITS))) >> (16 - ANGLE_FRAC_BITS);
  endfunction

  function automatic logic [ANGLE_W-1:0] clip16(longint v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hffff;
    return ANGLE_W'(v);
  endfunction

  function automatic angles_t predict_angles(logic [SIDE_W-1:0] sa, logic [SIDE_W-1:0] sb,
                                             logic [SIDE_W-1:0] sc);
    angles_t res;
    longint a;
    longint b;
    longint c;
    longint pa;
    longint pb;
    a = sa;
    b = sb;
    c = sc;
    res = '0;
    if (!(a + b > c && b + c > a && a + c > b)) return res;
    pa = acos_out(cosine_q16(b * b + c * c - a * a, 2 * b * c));
    pb = acos_out(cosine_q16(a * a + c * c - b * b, 2 * a * c));
    res.tri_ok = 1'b1;
    res.ang_a = clip16(pa);
    res.ang_b = clip16(pb);
    res.ang_c = clip16((longint'(180) << ANGLE_FRAC_BITS) - pa - pb);
    return res;
  endfunction

  // send one triple, idling at random before it
  task automatic send_sides(logic [SIDE_W-1:0] sa, logic [SIDE_W-1:0] sb,
                            logic [SIDE_W-1:0] sc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {sc, sb, sa};
    pending_angles.push_back(predict_angles(sa, sb, sc));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic go_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // random receiver stall
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each output item with the oldest prediction
  always @(posedge clk) begin
    angles_t want;
    angles_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser[0], m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]};
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %h", got);
      end else begin
        want = pending_angles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: tri %b/%b a %0d/%0d b %0d/%0d c %0d/%0d (exp/act)",
                     want.tri_ok, got.tri_ok, want.ang_a, got.ang_a,
                     want.ang_b, got.ang_b, want.ang_c, got.ang_c);
        end
      end
    end
  end

  task automatic test_extremes();
    send_sides(0, 0, 0);
    send_sides(1, 1, 1);
    send_sides(16'hffff, 16'hffff, 16'hffff);
    send_sides(16'hffff, 16'hffff, 1);
    send_sides(1, 16'hffff, 16'hffff);
    send_sides(16'hffff, 1, 16'hffff);
    send_sides(16'hffff, 0, 16'hffff);
    send_sides(3, 4, 5);
    send_sides(5, 3, 4);
    send_sides(4, 5, 3);
    send_sides(1, 2, 3);
    send_sides(2, 2, 3);
    send_sides(3, 2, 2);
    send_sides(16'hfffe, 16'h7fff, 16'h7fff);
    send_sides(16'hfffd, 16'h7fff, 16'h7fff);
    send_sides(100, 100, 199);
    send_sides(1, 100, 100);
    send_sides(16'haaaa, 16'h5555, 16'h8000);
    send_sides(16'h5555, 16'haaaa, 16'h7fff);
    go_idle();
  endtask

  task automatic test_random(int count);
    logic [SIDE_W-1:0] sa;
    logic [SIDE_W-1:0] sb;
    logic [SIDE_W-1:0] sc;
    int lim;
    for (int n = 0; n < count; n++) begin
      lim = ($urandom_range(3) == 0) ? 255 : 65535;
      sa = SIDE_W'($urandom_range(lim));
      sb = SIDE_W'($urandom_range(lim));
      sc = SIDE_W'($urandom_range(lim));
      if ($urandom_range(3) != 0) begin
        // mostly valid triangles; c inside (|a-b|, a+b)
        if (sa == 0) sa = 1;
        if (sb == 0) sb = 1;
        sc = SIDE_W'($urandom_range(((sa > sb) ? sa - sb : sb - sa) + 1,
                                    (32'(sa) + sb - 1 > 65535) ? 65535 : sa + sb - 1));
      end
      send_sides(sa, sb, sc);
    end
    go_idle();
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_angles.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    test_random(count);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    run_phase(0, 0, 125);
    run_phase(76, 0, 125);
    run_phase(0, 76, 125);
    run_phase(31, 31, 125);
    recv_stall_pct = 0;
    drain();
    if (mismatches == 0 && pending_angles.size() == 0) begin
      $display("triangle_angles_from_sides_tb: done, clean");
    end else begin
      $display("triangle_angles_from_sides_tb: done, errors");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("triangle_angles_from_sides_tb: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tafs_pkg.sv
hw/rtl/tafs_cosine.sv
hw/rtl/tafs_sine.sv
hw/rtl/tafs_cordic.sv
hw/rtl/triangle_angles_from_sides.sv
hw/rtl/tafs_checker.sv
verif/triangle_angles_from_sides_tb.sv
